// File: sv/hlid_pkg.sv
// Shared types and constants for the half-line image depacketizer.
package hlid_pkg;

	typedef enum logic [1:0] {
		FUNC_BYTE = 2'd0,
		FUNC_READ = 2'd1,
		FUNC_TAKE = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  byte_value;
		logic        first_byte;
		logic [11:0] datagram_length;
		logic [9:0]  pixel_x;
		logic [8:0]  pixel_y;
	} hlid_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_ready;
		logic [9:0] crop_left;
		logic [8:0] crop_top;
		logic [9:0] crop_right;
		logic [8:0] crop_bottom;
		logic       crop_valid;
	} hlid_rsp_t;

	localparam int          APB_AW       = 3;
	localparam logic        REG_FLUSH    = 1'b0;
	localparam logic [7:0]  FLUSH_RESET  = 8'd200;
	localparam logic [4:0]  SKIP_FIRST   = 5'd16;
	localparam logic [4:0]  SKIP_OTHER   = 5'd4;
	localparam int          HDR_BYTES    = 4;
	localparam int          CROP_END     = 12;
	localparam logic [15:0] CORNER_X2_RST = 16'd640;
	localparam logic [15:0] CORNER_Y2_RST = 16'd480;

	function automatic logic [7:0] expand5(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] c);
		return {c, c[5:4]};
	endfunction

endpackage

// File: sv/hlid_stream_if.sv
// Valid/ready stream channel carrying one payload per request.
interface hlid_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/half_line_image_depacketizer.sv
// Half-line image depacketizer: datagram parser, RGB565 frame store and pixel reader.
//
// request carries one request per cycle: a datagram byte (with first_byte and the
// datagram length), a pixel read, or a take-frame that clears frame-ready.
// Every request gives exactly one response on result: the colour of a read pixel
// (zero for other requests), frame_ready after the request and the clamped crop.
// The frame store is two byte-wide RAMs (low and high byte of each pixel), one
// write and one read port each, read data registered.
// Read stage, then output register; one request is taken every cycle while ready.
// A pixel read goes to the RAM in the cycle of its request; byte writes land at
// the same edge, so a read always sees every earlier byte.
// After reset a clearing pass writes zero to all FRAME_WIDTH*FRAME_HEIGHT pixel
// addresses, one a cycle; request.ready stays low meanwhile, APB writes are taken
// throughout.
// When result is stalled the response sits in the output register and one more
// request is held in the RAM read stage; then request.ready drops.
// flush_period sits at APB address 0; pready is always high.
module half_line_image_depacketizer import hlid_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480,
	parameter int MAX_DATAGRAM = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	hlid_stream_if.sink       request,
	hlid_stream_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int PIX   = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int STORE = PIX * 2;
	localparam int PAW   = $clog2(PIX);
	localparam int ABW   = PAW + 1;
	localparam int IW    = $clog2(MAX_DATAGRAM + 1);
	localparam int LW    = (IW > 12) ? IW : 12;
	localparam int SW    = ((ABW > LW) ? ABW : LW) + 1;
	localparam int RW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
	localparam int CW    = $clog2(FRAME_WIDTH);
	localparam int HW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
	localparam logic [31:0] CROP_NUM  = 32'(2 * FRAME_HEIGHT + 1);
	localparam logic [31:0] IMAGE_MAX = 32'(2 * FRAME_HEIGHT);

	typedef enum logic [1:0] {KIND_NONE, KIND_IMAGE, KIND_CROP} kind_t;

	typedef struct packed {
		logic       rd_ok;
		logic       frame_ready;
		logic [9:0] crop_left;
		logic [8:0] crop_top;
		logic [9:0] crop_right;
		logic [8:0] crop_bottom;
		logic       crop_valid;
	} meta_t;

	hlid_req_t p;
	assign p = request.payload;

	// config
	logic [7:0] flush_q;
	logic       cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FLUSH);
	assign prdata = (paddr[2] == REG_FLUSH) ? {24'b0, flush_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= FLUSH_RESET;
		end else if (cfg_wr) begin
			flush_q <= pwdata[7:0];
		end
	end

	// parser state
	logic [IW-1:0]   bidx_q, bidx_d, idx;
	logic [23:0]     pn_q, pn_d;
	logic [31:0]     pn_full, pn_less;
	kind_t           kind_q, kind_d;
	logic [4:0]      skip_q, skip_d, skip_calc;
	logic            we_q, we_d;
	logic [ABW-1:0]  base_q, base_d, base_calc;
	logic [LW-1:0]   plen_q, plen_d, len_eff;
	logic [7:0]      pc_q, pc_d, pc_inc;
	logic            flag_q, flag_d;
	logic [55:0]     stage_q, stage_d;
	logic [63:0]     stage_full;
	logic [15:0]     cor_q [4];
	logic [15:0]     cor_d [4];
	logic            live, fits;
	logic [SW-1:0]   waddr_full;
	logic            wr_en;
	logic [RW-1:0]   row;

	// handshake and pipeline
	logic            clr_busy_q;
	logic [PAW-1:0]  clr_cnt_q;
	logic            v_s1, res_v_q, adv, acc;
	meta_t           meta_s1, meta_d;
	hlid_rsp_t       res_q;

	assign adv           = !res_v_q || result.ready;
	assign request.ready = !clr_busy_q && (!v_s1 || adv);
	assign acc           = request.valid && request.ready;
	assign result.valid  = res_v_q;
	assign result.payload = res_q;

	always_comb begin
		len_eff = (LW'(p.datagram_length) > LW'(MAX_DATAGRAM)) ?
			LW'(MAX_DATAGRAM) : LW'(p.datagram_length);
		idx     = p.first_byte ? '0 : bidx_q;
		bidx_d  = (LW'(idx) < LW'(MAX_DATAGRAM)) ? idx + 1'b1 : idx;
		live    = LW'(idx) < len_eff;
		pn_full = {pn_q, p.byte_value};
		pn_less = pn_full - 32'd1;
		row     = RW'(pn_less[31:1]);
		base_calc = ABW'(row) * ABW'(2 * FRAME_WIDTH) +
			(pn_less[0] ? ABW'(FRAME_WIDTH) : '0);
		skip_calc = (pn_full == 32'd1) ? SKIP_FIRST : SKIP_OTHER;
		pc_inc  = pc_q + 8'd1;
		fits    = (SW'(base_q) + SW'(plen_q)) <= SW'(STORE);
		waddr_full = SW'(base_q) + SW'(idx) - SW'(skip_q);
		stage_full = {stage_q, p.byte_value};

		pn_d    = pn_q;
		kind_d  = kind_q;
		skip_d  = skip_q;
		we_d    = we_q;
		base_d  = base_q;
		plen_d  = plen_q;
		pc_d    = pc_q;
		flag_d  = flag_q;
		stage_d = stage_q;
		cor_d   = cor_q;
		wr_en   = 1'b0;

		case (p.func)
			FUNC_BYTE: begin
				if (live) begin
					if (idx < IW'(HDR_BYTES)) begin
						if (idx == '0) begin
							pn_d   = {16'b0, p.byte_value};
							kind_d = KIND_NONE;
							we_d   = 1'b0;
						end else begin
							pn_d = pn_full[23:0];
						end
						if (idx == IW'(HDR_BYTES - 1)) begin
							if (pn_full == CROP_NUM) begin
								kind_d  = KIND_CROP;
								stage_d = '0;
							end else if (pn_full >= 32'd1 && pn_full <= IMAGE_MAX) begin
								kind_d = KIND_IMAGE;
								skip_d = skip_calc;
								base_d = base_calc;
								we_d   = len_eff > LW'(skip_calc);
								plen_d = len_eff - LW'(skip_calc);
								if (pc_inc >= flush_q) begin
									flag_d = 1'b1;
									pc_d   = '0;
								end else begin
									pc_d = pc_inc;
								end
							end else begin
								kind_d = KIND_NONE;
							end
						end
					end else if (kind_q == KIND_IMAGE) begin
						wr_en = we_q && fits && (idx >= IW'(skip_q)) &&
							(waddr_full < SW'(STORE));
					end else if (kind_q == KIND_CROP && idx < IW'(CROP_END)) begin
						stage_d = stage_full[55:0];
						if (idx == IW'(CROP_END - 1)) begin
							cor_d[0] = stage_full[63:48];
							cor_d[1] = stage_full[47:32];
							cor_d[2] = stage_full[31:16];
							cor_d[3] = stage_full[15:0];
							flag_d   = 1'b1;
						end
					end
				end
			end
			FUNC_TAKE: flag_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bidx_q  <= '0;
			pn_q    <= '0;
			kind_q  <= KIND_NONE;
			skip_q  <= SKIP_OTHER;
			we_q    <= 1'b0;
			base_q  <= '0;
			plen_q  <= '0;
			pc_q    <= '0;
			flag_q  <= 1'b0;
			stage_q <= '0;
			cor_q[0] <= '0;
			cor_q[1] <= '0;
			cor_q[2] <= CORNER_X2_RST;
			cor_q[3] <= CORNER_Y2_RST;
		end else if (acc) begin
			if (p.func == FUNC_BYTE) begin
				bidx_q <= bidx_d;
			end
			pn_q    <= pn_d;
			kind_q  <= kind_d;
			skip_q  <= skip_d;
			we_q    <= we_d;
			base_q  <= base_d;
			plen_q  <= plen_d;
			pc_q    <= pc_d;
			flag_q  <= flag_d;
			stage_q <= stage_d;
			cor_q   <= cor_d;
		end
	end

	// crop clamp on the state after this request
	logic [CW-1:0] x1c, x2c;
	logic [HW-1:0] y1c, y2c;

	function automatic logic [15:0] clamp16(input logic [15:0] v, input int lim);
		return (32'(v) > 32'(lim - 1)) ? 16'(lim - 1) : v;
	endfunction

	// pixel read address
	logic           rd_ok;
	logic [PAW-1:0] raddr;

	always_comb begin
		x1c = CW'(clamp16(cor_d[0], FRAME_WIDTH));
		y1c = HW'(clamp16(cor_d[1], FRAME_HEIGHT));
		x2c = CW'(clamp16(cor_d[2], FRAME_WIDTH));
		y2c = HW'(clamp16(cor_d[3], FRAME_HEIGHT));
		rd_ok = (p.func == FUNC_READ) && (32'(p.pixel_x) < 32'(FRAME_WIDTH)) &&
			(32'(p.pixel_y) < 32'(FRAME_HEIGHT));
		raddr = PAW'(p.pixel_y) * PAW'(FRAME_WIDTH) + PAW'(p.pixel_x);
		meta_d.rd_ok       = rd_ok;
		meta_d.frame_ready = flag_d;
		meta_d.crop_left   = 10'(x1c);
		meta_d.crop_top    = 9'(y1c);
		meta_d.crop_right  = 10'(x2c);
		meta_d.crop_bottom = 9'(y2c);
		meta_d.crop_valid  = (x2c > x1c) && (y2c > y1c);
	end

	// frame store
	logic [7:0]     lo_mem [0:PIX-1];
	logic [7:0]     hi_mem [0:PIX-1];
	logic [7:0]     lo_rd_s1, hi_rd_s1;
	logic [PAW-1:0] waddr;
	logic [7:0]     wdata;
	logic           we_lo, we_hi;

	always_comb begin
		waddr = clr_busy_q ? clr_cnt_q : waddr_full[ABW-1:1];
		wdata = clr_busy_q ? 8'b0 : p.byte_value;
		we_lo = clr_busy_q || (acc && wr_en && !waddr_full[0]);
		we_hi = clr_busy_q || (acc && wr_en && waddr_full[0]);
	end

	always_ff @(posedge clk) begin
		if (we_lo) begin
			lo_mem[waddr] <= wdata;
		end
		if (we_hi) begin
			hi_mem[waddr] <= wdata;
		end
		if (acc && rd_ok) begin
			lo_rd_s1 <= lo_mem[raddr];
			hi_rd_s1 <= hi_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == PAW'(PIX - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				res_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			meta_s1 <= meta_d;
		end
		if (adv && v_s1) begin
			res_q.red         <= meta_s1.rd_ok ? expand5(hi_rd_s1[7:3]) : 8'b0;
			res_q.green       <= meta_s1.rd_ok ?
				expand6({hi_rd_s1[2:0], lo_rd_s1[7:5]}) : 8'b0;
			res_q.blue        <= meta_s1.rd_ok ? expand5(lo_rd_s1[4:0]) : 8'b0;
			res_q.frame_ready <= meta_s1.frame_ready;
			res_q.crop_left   <= meta_s1.crop_left;
			res_q.crop_top    <= meta_s1.crop_top;
			res_q.crop_right  <= meta_s1.crop_right;
			res_q.crop_bottom <= meta_s1.crop_bottom;
			res_q.crop_valid  <= meta_s1.crop_valid;
		end
	end

endmodule

// File: sim/half_line_image_depacketizer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the half-line image depacketizer: directed and random datagram traffic.
module half_line_image_depacketizer_test import hlid_pkg::*; ();

	localparam int FRAME_W    = 640;
	localparam int FRAME_H    = 480;
	localparam int MAX_DG     = 2048;
	localparam int STORE_SIZE = FRAME_W * FRAME_H * 2;
	localparam int CROP_PKT   = 2 * FRAME_H + 1;
	localparam int RUN_LIMIT  = 2000000;
	localparam logic [APB_AW-1:0] FLUSH_ADDR = APB_AW'(4 * REG_FLUSH);

	typedef enum {PKT_NONE, PKT_IMAGE, PKT_CROP} pkt_kind_t;
	typedef enum {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_LONG} sink_mode_t;
	typedef logic [7:0] byte_q_t[$];

	bit                clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	hlid_stream_if #(.payload_t(hlid_req_t)) req_ch ();
	hlid_stream_if #(.payload_t(hlid_rsp_t)) rsp_ch ();

	half_line_image_depacketizer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the depacketizer state
	bit [7:0]    shadow_frame [STORE_SIZE];
	int          dg_pos = 0;
	logic [31:0] pkt_num = '0;
	int          wr_base = 0;
	bit          wr_en = 1'b0;
	pkt_kind_t   pkt_kind = PKT_NONE;
	int          hdr_skip = SKIP_OTHER;
	logic [63:0] corner_stage = '0;
	logic [15:0] corners [4] = '{16'd0, 16'd0, CORNER_X2_RST, CORNER_Y2_RST};
	logic [7:0]  pkt_count = '0;
	bit          frame_flag = 1'b0;
	logic [7:0]  flush_period = FLUSH_RESET;

	hlid_rsp_t   frame_views_due[$];
	int          written_pixels[$];
	int          fault_count = 0;
	int unsigned cycle_count = 0;
	int          request_count = 0;
	int          burst_left = 0;
	int          gap_max = 4;

	function automatic int clamp_corner(logic [15:0] v, int lim);
		return (int'(v) > lim - 1) ? lim - 1 : int'(v);
	endfunction

	function automatic void take_datagram_byte(logic [7:0] b, logic first, logic [11:0] len_in);
		int len;
		int idx;
		int n;
		int addr;
		len = (int'(len_in) > MAX_DG) ? MAX_DG : int'(len_in);
		if (first)
			dg_pos = 0;
		idx = dg_pos;
		if (dg_pos < MAX_DG)
			dg_pos++;
		if (idx >= len)
			return;
		if (idx < HDR_BYTES) begin
			pkt_num = (idx == 0) ? {24'd0, b} : {pkt_num[23:0], b};
			if (idx == 0) begin
				pkt_kind = PKT_NONE;
				wr_en = 1'b0;
			end
			if (idx == HDR_BYTES - 1) begin
				if (pkt_num == CROP_PKT) begin
					pkt_kind = PKT_CROP;
					corner_stage = '0;
				end else if (pkt_num >= 1 && pkt_num <= 2 * FRAME_H) begin
					n = int'(pkt_num) - 1;
					pkt_kind = PKT_IMAGE;
					hdr_skip = (pkt_num == 1) ? SKIP_FIRST : SKIP_OTHER;
					wr_base = (n >> 1) * FRAME_W * 2 + ((n & 1) ? FRAME_W : 0);
					wr_en = len > hdr_skip && wr_base + len - hdr_skip <= STORE_SIZE;
					pkt_count = pkt_count + 8'd1;
					if (pkt_count >= flush_period) begin
						frame_flag = 1'b1;
						pkt_count = '0;
					end
				end else begin
					pkt_kind = PKT_NONE;
				end
			end
			return;
		end
		if (pkt_kind == PKT_IMAGE) begin
			if (wr_en && idx >= hdr_skip) begin
				addr = wr_base + idx - hdr_skip;
				if (addr < STORE_SIZE) begin
					shadow_frame[addr] = b;
					written_pixels.push_back(addr >> 1);
					if (written_pixels.size() > 64)
						void'(written_pixels.pop_front());
				end
			end
		end else if (pkt_kind == PKT_CROP && idx < CROP_END) begin
			corner_stage = {corner_stage[55:0], b};
			if (idx == CROP_END - 1) begin
				corners[0] = corner_stage[63:48];
				corners[1] = corner_stage[47:32];
				corners[2] = corner_stage[31:16];
				corners[3] = corner_stage[15:0];
				frame_flag = 1'b1;
			end
		end
	endfunction

	function automatic hlid_rsp_t frame_view_after(hlid_req_t r);
		hlid_rsp_t   v;
		logic [15:0] px;
		int          p;
		int          x1;
		int          y1;
		int          x2;
		int          y2;
		v = '0;
		case (r.func)
			FUNC_BYTE: take_datagram_byte(r.byte_value, r.first_byte, r.datagram_length);
			FUNC_READ: begin
				if (r.pixel_x < FRAME_W && r.pixel_y < FRAME_H) begin
					p = (int'(r.pixel_y) * FRAME_W + int'(r.pixel_x)) * 2;
					px = {shadow_frame[p + 1], shadow_frame[p]};
					v.red = {px[15:11], px[15:13]};
					v.green = {px[10:5], px[10:9]};
					v.blue = {px[4:0], px[4:2]};
				end
			end
			FUNC_TAKE: frame_flag = 1'b0;
			default: ;
		endcase
		x1 = clamp_corner(corners[0], FRAME_W);
		y1 = clamp_corner(corners[1], FRAME_H);
		x2 = clamp_corner(corners[2], FRAME_W);
		y2 = clamp_corner(corners[3], FRAME_H);
		v.frame_ready = frame_flag;
		v.crop_left = 10'(x1);
		v.crop_top = 9'(y1);
		v.crop_right = 10'(x2);
		v.crop_bottom = 9'(y2);
		v.crop_valid = (x2 > x1) && (y2 > y1);
		return v;
	endfunction

	function automatic hlid_req_t scrambled_request();
		hlid_req_t r;
		r.func = func_t'($urandom_range(0, 3));
		r.byte_value = 8'($urandom);
		r.first_byte = 1'($urandom);
		r.datagram_length = 12'($urandom);
		r.pixel_x = 10'($urandom);
		r.pixel_y = 9'($urandom);
		return r;
	endfunction

	function automatic byte_q_t header_of(logic [31:0] num);
		byte_q_t q;
		q = '{num[31:24], num[23:16], num[15:8], num[7:0]};
		return q;
	endfunction

	function automatic logic [15:0] pick_corner(bit vertical);
		int lim;
		lim = vertical ? FRAME_H : FRAME_W;
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'(lim - 1);
			2: return 16'(lim);
			3: return 16'hFFFF;
			4: return 16'($urandom);
			default: return 16'($urandom_range(0, lim - 1));
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
		$display("%0t ERROR %s expected %0d actual %0d", $time, field, want, got);
		fault_count++;
	endtask

	// entered and left at a falling edge; valid stays high into the next request of a burst
	task automatic issue_request(hlid_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		frame_views_due.push_back(frame_view_after(r));
		request_count++;
		@(negedge clk);
	endtask

	task automatic wait_until_idle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (frame_views_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_flush_period(logic [7:0] value);
		logic [23:0] upper;
		upper = 24'($urandom);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= FLUSH_ADDR;
		pwdata <= {upper, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		flush_period = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[7:0] !== flush_period)
			report_mismatch("flush_period", flush_period, prdata[7:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_byte(logic [7:0] b, bit first, int len);
		hlid_req_t r;
		r = scrambled_request();
		r.func = FUNC_BYTE;
		r.byte_value = b;
		r.first_byte = first;
		r.datagram_length = 12'(len);
		issue_request(r);
	endtask

	task automatic send_read(int x, int y);
		hlid_req_t r;
		r = scrambled_request();
		r.func = FUNC_READ;
		r.pixel_x = 10'(x);
		r.pixel_y = 9'(y);
		issue_request(r);
	endtask

	task automatic send_command(func_t f);
		hlid_req_t r;
		r = scrambled_request();
		r.func = f;
		issue_request(r);
	endtask

	task automatic send_side_request();
		int pick;
		int sel;
		int pix;
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 9);
		if (pick < 60) begin
			if (sel < 5 && written_pixels.size() != 0) begin
				pix = written_pixels[$urandom_range(0, written_pixels.size() - 1)];
				send_read(pix % FRAME_W, pix / FRAME_W);
			end else if (sel < 8)
				send_read($urandom_range(0, FRAME_W - 1), $urandom_range(0, FRAME_H - 1));
			else if (sel == 8)
				send_read($urandom_range(FRAME_W, 1023), $urandom_range(0, 511));
			else
				send_read($urandom_range(0, 1023), $urandom_range(FRAME_H, 511));
		end else if (pick < 85)
			send_command(FUNC_TAKE);
		else
			send_command(FUNC_NOP);
	endtask

	// noisy: other requests slip in between bytes, and the length field now and then jumps
	task automatic send_datagram(byte_q_t dg, int len, bit lead_first, bit noisy);
		foreach (dg[i]) begin
			if (noisy && $urandom_range(0, 11) == 0)
				send_side_request();
			if (noisy && $urandom_range(0, 49) == 0)
				send_byte(dg[i], lead_first && i == 0, $urandom_range(1, 4095));
			else
				send_byte(dg[i], lead_first && i == 0, len);
		end
	endtask

	task automatic send_image_packet();
		byte_q_t dg;
		int      num;
		int      skip;
		int      len;
		int      sent;
		int      shape;
		case ($urandom_range(0, 5))
			0: num = 1;
			1: num = 2 * FRAME_H;
			2: num = 2;
			default: num = $urandom_range(1, 2 * FRAME_H);
		endcase
		skip = (num == 1) ? SKIP_FIRST : SKIP_OTHER;
		shape = $urandom_range(0, 9);
		if (shape < 7)
			len = skip + $urandom_range(1, 24);
		else if (shape < 9)
			len = $urandom_range(HDR_BYTES, skip);
		else begin
			len = $urandom_range(FRAME_W, 4095);
			if (num == 2 * FRAME_H && $urandom_range(0, 1))
				len = FRAME_W + SKIP_OTHER + $urandom_range(0, 1);
		end
		sent = (len <= skip + 24) ? len + $urandom_range(0, 2) : skip + $urandom_range(0, 24);
		dg = header_of(num);
		while (dg.size() < sent)
			dg.push_back(8'($urandom));
		send_datagram(dg, len, 1'b1, 1'b1);
	endtask

	task automatic send_crop_packet(bit cut_short);
		byte_q_t     dg;
		int          len;
		int          sent;
		logic [15:0] c;
		dg = header_of(CROP_PKT);
		for (int k = 0; k < 4; k++) begin
			c = pick_corner(k[0]);
			dg.push_back(c[15:8]);
			dg.push_back(c[7:0]);
		end
		if (cut_short)
			len = $urandom_range(HDR_BYTES, CROP_END - 1);
		else
			case ($urandom_range(0, 3))
				0, 1: len = CROP_END;
				2: len = $urandom_range(CROP_END + 1, 40);
				default: len = $urandom_range(MAX_DG, 4095);
			endcase
		sent = cut_short ? CROP_END : CROP_END + $urandom_range(0, 3);
		while (dg.size() < sent)
			dg.push_back(8'($urandom));
		send_datagram(dg, len, 1'b1, 1'b1);
	endtask

	task automatic send_other_packet();
		byte_q_t     dg;
		logic [31:0] num;
		int          len;
		int          sent;
		case ($urandom_range(0, 4))
			0: num = '0;
			1: num = CROP_PKT + 1;
			2: num = '1;
			3: num = 32'h0100_0001;
			default: num = $urandom;
		endcase
		len = $urandom_range(HDR_BYTES, 40);
		sent = HDR_BYTES + $urandom_range(0, 8);
		if (sent > len)
			sent = len;
		dg = header_of(num);
		while (dg.size() < sent)
			dg.push_back(8'($urandom));
		send_datagram(dg, len, 1'b1, 1'b1);
	endtask

	task automatic send_short_datagram();
		byte_q_t dg;
		int      len;
		len = $urandom_range(1, HDR_BYTES - 1);
		repeat (len + $urandom_range(0, 2))
			dg.push_back(8'($urandom));
		send_datagram(dg, len, 1'b1, 1'b1);
	endtask

	task automatic send_headless_bytes();
		byte_q_t dg;
		repeat ($urandom_range(1, 8))
			dg.push_back(8'($urandom));
		send_datagram(dg, $urandom_range(1, 60), 1'b0, 1'b1);
	endtask

	task automatic test_reset_view();
		send_command(FUNC_NOP);
		send_read(5, 5);
		send_command(FUNC_TAKE);
	endtask

	task automatic test_directed_cases();
		byte_q_t dg;
		// crop: left beyond range, right at width, so both clamp to the last column
		dg = header_of(CROP_PKT);
		dg.push_back(8'hFF);
		dg.push_back(8'hFF);
		dg.push_back(8'h00);
		dg.push_back(8'h05);
		dg.push_back(8'h02);
		dg.push_back(8'h80);
		dg.push_back(8'h01);
		dg.push_back(8'hE0);
		send_datagram(dg, CROP_END, 1'b1, 1'b0);
		send_read(0, 0);
		send_read(FRAME_W - 1, FRAME_H - 1);
		send_read(1023, 511);
		send_command(FUNC_TAKE);
		send_command(FUNC_NOP);
		// datagram too short for a packet number
		dg = '{8'h00, 8'h01};
		send_datagram(dg, 2, 1'b1, 1'b0);
		send_read(FRAME_W - 1, 0);
		wait_until_idle();
	endtask

	// one long datagram with no further first byte: the byte index must stop at its limit
	task automatic test_index_saturation();
		byte_q_t dg;
		dg = header_of(1);
		while (dg.size() < MAX_DG + 60)
			dg.push_back(8'($urandom));
		send_datagram(dg, 4095, 1'b1, 1'b0);
		repeat (8)
			send_read($urandom_range(0, FRAME_W - 1), $urandom_range(0, 1));
		send_read(MAX_DG / 2 - SKIP_FIRST / 2 - 1 - FRAME_W, 1);
		wait_until_idle();
	endtask

	task automatic test_random_traffic(int items);
		int stop_at;
		int pick;
		stop_at = request_count + items;
		while (request_count < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_image_packet();
			else if (pick < 50)
				send_crop_packet(1'b0);
			else if (pick < 55)
				send_crop_packet(1'b1);
			else if (pick < 62)
				send_other_packet();
			else if (pick < 66)
				send_short_datagram();
			else if (pick < 70)
				send_headless_bytes();
			else
				repeat ($urandom_range(1, 4))
					send_side_request();
		end
		wait_until_idle();
	endtask

	sink_mode_t sink_mode = SINK_OPEN;
	int         sink_hold = 0;
	int         sink_stall = 0;
	int         sink_tick = 0;

	always @(negedge clk) begin
		if (sink_hold == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_hold = $urandom_range(16, 160);
		end else
			sink_hold--;
		sink_tick++;
		case (sink_mode)
			SINK_OPEN: rsp_ch.ready <= 1'b1;
			SINK_COIN: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
			SINK_PERIODIC: rsp_ch.ready <= ((sink_tick % 7) >= 3);
			default: begin
				if (sink_stall == 0 && $urandom_range(0, 9) == 0)
					sink_stall = $urandom_range(1, 12);
				if (sink_stall > 0) begin
					sink_stall--;
					rsp_ch.ready <= 1'b0;
				end else
					rsp_ch.ready <= 1'b1;
			end
		endcase
	end

	always @(posedge clk) begin
		hlid_rsp_t want;
		hlid_rsp_t got;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.payload;
			if (frame_views_due.size() == 0) begin
				$display("%0t ERROR result expected none actual %h", $time, got);
				fault_count++;
			end else begin
				want = frame_views_due.pop_front();
				if (got.red !== want.red)
					report_mismatch("red", want.red, got.red);
				if (got.green !== want.green)
					report_mismatch("green", want.green, got.green);
				if (got.blue !== want.blue)
					report_mismatch("blue", want.blue, got.blue);
				if (got.frame_ready !== want.frame_ready)
					report_mismatch("frame_ready", want.frame_ready, got.frame_ready);
				if (got.crop_left !== want.crop_left)
					report_mismatch("crop_left", want.crop_left, got.crop_left);
				if (got.crop_top !== want.crop_top)
					report_mismatch("crop_top", want.crop_top, got.crop_top);
				if (got.crop_right !== want.crop_right)
					report_mismatch("crop_right", want.crop_right, got.crop_right);
				if (got.crop_bottom !== want.crop_bottom)
					report_mismatch("crop_bottom", want.crop_bottom, got.crop_bottom);
				if (got.crop_valid !== want.crop_valid)
					report_mismatch("crop_valid", want.crop_valid, got.crop_valid);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("half_line_image_depacketizer_test: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_view();
		test_directed_cases();
		test_random_traffic(160);
		set_flush_period(8'd1);
		gap_max = 0;
		test_random_traffic(160);
		set_flush_period(8'd255);
		gap_max = 8;
		test_random_traffic(160);
		set_flush_period(8'd0);
		gap_max = 3;
		test_random_traffic(160);
		test_index_saturation();
		set_flush_period(8'($urandom_range(2, 254)));
		gap_max = 5;
		test_random_traffic(160);

		wait_until_idle();
		repeat (16) @(negedge clk);
		if (fault_count == 0)
			$display("half_line_image_depacketizer_test: PASS");
		else
			$display("half_line_image_depacketizer_test: FAIL");
		$finish;
	end

endmodule
